// ----- hw/rtl/rms_decibel_level_meter_macros.svh -----
// Assertion macros for the RMS decibel level meter
`ifndef RMS_DECIBEL_LEVEL_METER_MACROS_SVH
`define RMS_DECIBEL_LEVEL_METER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RDLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RDLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rdlm_pkg.sv -----
// Shared types, constants and the decibel threshold table of the level meter
package rdlm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FL_W      = 13;
    localparam int FL_RESET  = 1024;
    localparam int FL_MAX    = 2 ** FL_W - 1;
    localparam int ACC_W     = 43;
    localparam int QUO_W     = 43;
    localparam int SQ_W      = 31;
    localparam int LVL_W     = 7;
    localparam int MEAN_W    = 31;
    localparam int DB_MAX    = 83;
    localparam int OUT_TDATA_W = 40;

    // 0.45255 squared, scaled by 10^10
    localparam int KSQ_W = 31;
    localparam logic [KSQ_W-1:0] KSQ = 31'd2048015025;

    localparam int PROD_W     = 64;
    localparam int MUL_LO_W   = 22;
    localparam int MUL_HI_W   = QUO_W - MUL_LO_W;
    localparam int MUL_PROD_W = MUL_LO_W + KSQ_W;

    localparam int STEP_W = $clog2(QUO_W);
    localparam int BIT_W  = $clog2(LVL_W);

    // Wide enough for x^10 with x below 2^64
    localparam int BIG_W = 10 * PROD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_DIVIDE,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_SEARCH,
        S_OUTPUT
    } t_state;

    typedef struct packed {
        logic             load_sample;
        logic             square;
        logic             accum;
        logic             div_step;
        logic             mul_lo;
        logic             mul_hi;
        logic             prod_sum;
        logic             search;
        logic [BIT_W-1:0] bit_pos;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_end;
        logic out_free;
    } t_dp_stat;

    typedef logic [DB_MAX:0][PROD_W-1:0] t_db_table;

    function automatic logic [BIG_W-1:0] pow_ten10(input logic [PROD_W-1:0] x);
        logic [BIG_W-1:0] x2;
        logic [BIG_W-1:0] x4;
        logic [BIG_W-1:0] x8;
        x2 = BIG_W'(x) * BIG_W'(x);
        x4 = x2 * x2;
        x8 = x4 * x4;
        return x8 * x2;
    endfunction

    // Smallest x with x^10 >= 10^(d+100): level >= d exactly when (m*KSQ) reaches it
    function automatic logic [PROD_W-1:0] db_root(input int d);
        logic [BIG_W-1:0]  p;
        logic [PROD_W:0]   lo;
        logic [PROD_W:0]   hi;
        logic [PROD_W:0]   mid;
        p  = BIG_W'(1);
        lo = '0;
        hi = (PROD_W + 1)'(1) << (PROD_W - 1);
        for (int i = 0; i < d + 100; i++) begin
            p = p * BIG_W'(10);
        end
        for (int it = 0; it < PROD_W + 2; it++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (pow_ten10(mid[PROD_W-1:0]) >= p) begin
                    hi = mid;
                end else begin
                    lo = mid + (PROD_W + 1)'(1);
                end
            end
        end
        return lo[PROD_W-1:0];
    endfunction

    function automatic t_db_table db_table();
        t_db_table t;
        t = '0;
        for (int d = 1; d <= DB_MAX; d++) begin
            t[d] = db_root(d);
        end
        return t;
    endfunction

    localparam t_db_table DB_THRESH = db_table();

endpackage

// ----- hw/rtl/rdlm_ctrl.sv -----
// Controller state machine sequencing accumulate, divide, multiply and level search
module rdlm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rdlm_pkg::t_dp_stat i_stat,
    output rdlm_pkg::t_dp_cmd  o_cmd
);
    import rdlm_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_sample = 1'b1;
                    n_state           = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_step      = '0;
                n_state     = i_stat.frame_end ? S_DIVIDE : S_IDLE;
            end
            S_DIVIDE: begin
                // one quotient bit per cycle
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.prod_sum = 1'b1;
                n_step         = '0;
                n_state        = S_SEARCH;
            end
            S_SEARCH: begin
                // settle the level one bit per cycle, MSB first
                o_cmd.search  = 1'b1;
                o_cmd.bit_pos = BIT_W'(LVL_W - 1) - r_step[BIT_W-1:0];
                n_step        = r_step + STEP_W'(1);
                if (r_step == STEP_W'(LVL_W - 1)) begin
                    n_state = S_OUTPUT;
                end
            end
            S_OUTPUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rdlm_datapath.sv -----
// Datapath: square and accumulate, bit-serial divide, scaling multiply, level search
module rdlm_datapath #(
    parameter int MAX_FRAME = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rdlm_pkg::t_dp_cmd                 i_cmd,
    output rdlm_pkg::t_dp_stat                o_stat,
    input  logic signed [rdlm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_cfg_wr_en,
    input  logic [rdlm_pkg::FL_W-1:0]         i_cfg_wr_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rdlm_pkg::LVL_W-1:0]        o_level,
    output logic [rdlm_pkg::MEAN_W-1:0]       o_mean
);
    import rdlm_pkg::*;

    localparam int EFF_MAX = (MAX_FRAME < FL_MAX) ? MAX_FRAME : FL_MAX;
    localparam int LEN_W   = $clog2(EFF_MAX + 1);

    logic [FL_W-1:0]              r_frame_length;
    logic [ACC_W-1:0]             r_acc;
    logic [LEN_W-1:0]             r_cnt;
    logic                         r_out_valid;

    logic signed [SAMPLE_W-1:0]   r_sample;
    logic [SQ_W-1:0]              r_square;
    logic [LEN_W-1:0]             r_div;
    logic [LEN_W-1:0]             r_rem;
    logic [QUO_W-1:0]             r_quo;
    logic [MUL_PROD_W-1:0]        r_part;
    logic [PROD_W-1:0]            r_prod;
    logic [LVL_W-1:0]             r_lvl;
    logic [LVL_W-1:0]             r_out_level;
    logic [MEAN_W-1:0]            r_out_mean;

    logic [LEN_W-1:0]             len_eff;
    logic [LEN_W:0]               cnt_inc;
    logic                         frame_end;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [ACC_W-1:0]             acc_sum;
    logic [LEN_W:0]               rem_sh;
    logic [LEN_W:0]               rem_sub;
    logic                         rem_ge;
    logic [MUL_LO_W-1:0]          mul_a;
    logic [MUL_PROD_W-1:0]        mul_p;
    logic [LVL_W-1:0]             cand;
    logic                         hit;

    // Zero length counts as one, long frames saturate
    always_comb begin
        if (r_frame_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(r_frame_length) > EFF_MAX) begin
            len_eff = LEN_W'(EFF_MAX);
        end else begin
            len_eff = LEN_W'(r_frame_length);
        end
    end

    assign cnt_inc   = {1'b0, r_cnt} + (LEN_W + 1)'(1);
    assign frame_end = cnt_inc >= {1'b0, len_eff};
    assign sq_full   = r_sample * r_sample;
    assign acc_sum   = r_acc + ACC_W'(r_square);

    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    assign mul_a = i_cmd.mul_hi ? MUL_LO_W'(r_quo[QUO_W-1:MUL_LO_W]) : r_quo[MUL_LO_W-1:0];
    assign mul_p = MUL_PROD_W'(mul_a) * MUL_PROD_W'(KSQ);

    assign cand = r_lvl | (LVL_W'(1) << i_cmd.bit_pos);
    assign hit  = (cand <= LVL_W'(DB_MAX)) && (r_prod >= DB_THRESH[cand]);

    assign o_stat.frame_end = frame_end;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FL_W'(FL_RESET);
            r_acc          <= '0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_length <= i_cfg_wr_data;
            end
            if (i_cmd.accum) begin
                if (frame_end) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= acc_sum;
                    r_cnt <= cnt_inc[LEN_W-1:0];
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
        end
        if (i_cmd.square) begin
            // signed square is never negative and at most 2^30
            r_square <= sq_full[SQ_W-1:0];
        end
        if (i_cmd.accum && frame_end) begin
            r_quo <= acc_sum;
            r_rem <= '0;
            r_div <= len_eff;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        end
        if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(mul_p);
        end
        if (i_cmd.mul_hi) begin
            r_part <= mul_p;
        end
        if (i_cmd.prod_sum) begin
            // product kept modulo 2^64
            r_prod <= r_prod + PROD_W'({r_part, {MUL_LO_W{1'b0}}});
            r_lvl  <= '0;
        end
        if (i_cmd.search && hit) begin
            r_lvl <= cand;
        end
        if (i_cmd.load_out) begin
            r_out_level <= r_lvl;
            r_out_mean  <= r_quo[MEAN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_mean      = r_out_mean;

endmodule

// ----- hw/rtl/rms_decibel_level_meter.sv -----
// RMS decibel level meter top level: stream ports, controller and datapath
//
// Takes signed 16-bit samples, sums their squares over frame_length samples
// (zero counts as one, longer than MAX_FRAME saturates) and at each frame end
// returns the truncated mean square together with trunc(20*log10(0.45255*rms))
// clamped at zero, 0..83 dB. Each sample is accepted, squared and accumulated;
// the frame-closing sample then runs the bit-serial restoring divider, the
// split 22x31 scaling multiply and its sum, the bitwise threshold search and
// the load of the output register, which waits while a previous result has
// not been taken. No new sample is taken until this sequence is done. The
// output register lets the next frame run while a result waits.
`include "rms_decibel_level_meter_macros.svh"

module rms_decibel_level_meter #(
    parameter int MAX_FRAME = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [rdlm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata, // [6:0] level_db, [37:7] mean_square
    input  logic        i_cfg_wr_en,
    input  logic [rdlm_pkg::FL_W-1:0] i_cfg_wr_data
);
    import rdlm_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - MEAN_W - LVL_W;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [LVL_W-1:0]   level;
    logic [MEAN_W-1:0]  mean;

    rdlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rdlm_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_sample      (signed'(i_s_axis_tdata)),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_level       (level),
        .o_mean        (mean)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, mean, level};

    `RDLM_ASSERT_NOW(a_level_range, i_clk, i_rst_n, o_m_axis_tvalid, (level <= LVL_W'(DB_MAX)), "level above table range")
    `RDLM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready), !o_s_axis_tready, "input taken while a sample is in work")
    `RDLM_ASSERT_NOW(a_result_frees_input, i_clk, i_rst_n, $rose(o_m_axis_tvalid), o_s_axis_tready, "new result without return to idle")

endmodule

// ----- bench/rms_decibel_level_meter_tb.sv -----
// Self-checking testbench for the RMS decibel level meter: directed table, random audio frames
`timescale 1ns / 1ps

module rms_decibel_level_meter_tb;

    localparam int unsigned MAX_FRAME_LEN = 4096;
    localparam int unsigned LEVEL_TOP     = 83;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned SINK_HOLD     = 400;
    // 0.45255 squared, times 10^10
    localparam logic [30:0] GAIN_SQ_E10   = 31'd2048015025;

    // frame styles of the random audio
    localparam int unsigned STYLE_SILENT  = 0;
    localparam int unsigned STYLE_PINNED  = 1;
    localparam int unsigned STYLE_FULL    = 17;

    typedef struct packed {
        logic [6:0]  level_db;
        logic [30:0] mean_square;
    } t_level_result;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_CHECKED,
        ROW_FRAME_LEN
    } t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        logic [15:0]   value;
        t_level_result res;
    } t_dir_row;

    localparam int N_DIR = 27;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // reset length still in force: no frame closes
        '{ROW_SAMPLE,    16'h7FFF, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h8000, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h0000, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h0001, '{7'd0, 31'd0}},
        // lowered below the count: the next sample closes the frame, divisor 3
        '{ROW_FRAME_LEN, 16'd3,    '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'hFFFF, '{7'd0, 31'd0}},
        '{ROW_FRAME_LEN, 16'd1,    '{7'd0, 31'd0}},
        '{ROW_CHECKED,   16'h8000, '{7'd83, 31'h4000_0000}},
        '{ROW_CHECKED,   16'h7FFF, '{7'd83, 31'd1073676289}},
        '{ROW_CHECKED,   16'h0000, '{7'd0, 31'd0}},
        '{ROW_CHECKED,   16'h0001, '{7'd0, 31'd1}},
        '{ROW_CHECKED,   16'hFFFF, '{7'd0, 31'd1}},
        '{ROW_SAMPLE,    16'h0002, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h0003, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h0064, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h03E8, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'hCFC7, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h5555, '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'hAAAA, '{7'd0, 31'd0}},
        // zero length acts as one
        '{ROW_FRAME_LEN, 16'd0,    '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h0007, '{7'd0, 31'd0}},
        '{ROW_CHECKED,   16'h8000, '{7'd83, 31'h4000_0000}},
        '{ROW_FRAME_LEN, 16'd2,    '{7'd0, 31'd0}},
        '{ROW_SAMPLE,    16'h8000, '{7'd0, 31'd0}},
        '{ROW_CHECKED,   16'h8000, '{7'd83, 31'h4000_0000}},
        // mean of one half truncates to silence
        '{ROW_SAMPLE,    16'h0001, '{7'd0, 31'd0}},
        '{ROW_CHECKED,   16'h0000, '{7'd0, 31'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [rdlm_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic        cfg_wr_en;
    logic [12:0] cfg_wr_data;

    // meter shadow state
    logic [12:0]   frame_len_q;
    logic [42:0]   energy_sum;
    int unsigned   frame_fill;
    t_level_result pending_levels [$];

    bit            failed;
    bit            idle_on;
    bit            long_hold_req;
    int unsigned   sink_hold;
    int unsigned   frame_style;
    t_level_result got_level;
    t_level_result want_level;

    rms_decibel_level_meter i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),      // [15:0] sample
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),      // [6:0] level_db, [37:7] mean_square
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    always #4 clk = ~clk;

    // Count the dB thresholds reached: level >= d exactly when (m*K)^10 >= 10^(d+100)
    function automatic logic [6:0] db_of_mean(input logic [30:0] m);
        logic [639:0] x;
        logic [639:0] pwr;
        logic [639:0] bound;
        int unsigned  d;
        int           i;
        if (m == 31'd0) begin
            return 7'd0;
        end
        x = 640'(m) * 640'(GAIN_SQ_E10);
        pwr = 640'd1;
        for (i = 0; i < 10; i++) begin
            pwr = pwr * x;
        end
        bound = 640'd1;
        for (i = 0; i < 101; i++) begin
            bound = bound * 640'd10;
        end
        d = 0;
        while (d < LEVEL_TOP && pwr >= bound) begin
            d++;
            bound = bound * 640'd10;
        end
        return 7'(d);
    endfunction

    task automatic meter_step(input logic [15:0] s, output bit closed,
                              output t_level_result r);
        logic [15:0] mag;
        logic [42:0] eff_len;
        mag = s[15] ? (~s + 16'd1) : s;
        if (frame_len_q == 13'd0) begin
            eff_len = 43'd1;
        end else if (frame_len_q > MAX_FRAME_LEN) begin
            eff_len = 43'(MAX_FRAME_LEN);
        end else begin
            eff_len = 43'(frame_len_q);
        end
        energy_sum = energy_sum + 43'(mag) * 43'(mag);
        frame_fill++;
        closed = (frame_fill >= eff_len);
        r = '0;
        if (closed) begin
            r.mean_square = 31'(energy_sum / eff_len);
            r.level_db    = db_of_mean(r.mean_square);
            energy_sum    = '0;
            frame_fill    = 0;
        end
    endtask

    function automatic logic [15:0] audio_sample(input int unsigned style);
        logic [15:0] raw;
        raw = 16'($urandom);
        if (style == STYLE_SILENT) begin
            return 16'h0000;
        end
        if (style == STYLE_PINNED) begin
            return 16'h8000;
        end
        if (style >= STYLE_FULL) begin
            return raw;
        end
        // scale down to an amplitude of 2^(style-2)
        return 16'($signed(raw) >>> (STYLE_FULL - style));
    endfunction

    task automatic send_sample(input logic [15:0] s, input bit use_typed,
                               input t_level_result typed_res);
        int unsigned   gap;
        bit            closed;
        t_level_result want;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        meter_step(s, closed, want);
        if (closed) begin
            pending_levels.push_back(use_typed ? typed_res : want);
        end
    endtask

    // Drop valid, wait for every pending level, then let the block go quiet
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frame_len(input logic [12:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        frame_len_q = v;
    endtask

    task automatic run_phase(input logic [12:0] len, input int unsigned n,
                             input bit hold_sink);
        int unsigned k;
        write_frame_len(len);
        if (hold_sink) begin
            long_hold_req = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            if (frame_fill == 0) begin
                frame_style = $urandom_range(STYLE_SILENT, STYLE_FULL + 2);
            end
            send_sample(audio_sample(frame_style), 1'b0, '0);
        end
    endtask

    // Sink side: random stall bursts, plus one long hold-off on request
    always @(negedge clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            sink_hold <= SINK_HOLD - 1;
            m_tready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(1, 14) - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_level.level_db    = m_tdata[6:0];
            got_level.mean_square = m_tdata[37:7];
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result, expected none, got level_db %0d mean_square %0d",
                         $time, got_level.level_db, got_level.mean_square);
                failed = 1'b1;
            end else begin
                want_level = pending_levels.pop_front();
                if (got_level.level_db !== want_level.level_db) begin
                    $display("%0t: level_db expected %0d got %0d", $time,
                             want_level.level_db, got_level.level_db);
                    failed = 1'b1;
                end
                if (got_level.mean_square !== want_level.mean_square) begin
                    $display("%0t: mean_square expected %0d got %0d", $time,
                             want_level.mean_square, got_level.mean_square);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int i;
        int p;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        frame_len_q   = 13'd1024;
        energy_sum    = '0;
        frame_fill    = 0;
        failed        = 1'b0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        sink_hold     = 0;
        frame_style   = STYLE_FULL;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            case (DIR_ROWS[i].kind)
                ROW_FRAME_LEN: begin
                    write_frame_len(DIR_ROWS[i].value[12:0]);
                end
                ROW_CHECKED: begin
                    send_sample(DIR_ROWS[i].value, 1'b1, DIR_ROWS[i].res);
                end
                default: begin
                    send_sample(DIR_ROWS[i].value, 1'b0, '0);
                end
            endcase
        end

        // hold the sink off while one-sample frames pile up
        run_phase(13'd1, 40, 1'b1);
        for (p = 0; p < 6; p++) begin
            run_phase(13'($urandom_range(2, 24)), $urandom_range(20, 40), 1'b0);
        end
        // saturates to the largest frame, then a shorter length closes it
        run_phase(13'd8191, 30, 1'b0);
        run_phase(13'd100, 80, 1'b0);
        run_phase(13'($urandom_range(1, 13)), 30, 1'b0);

        idle_on = 1'b0;
        run_phase(13'd3, 60, 1'b0);

        drain_results();
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
